// ----- rtl/rsfl_pkg.sv -----
// Shared types and constants of the receive slot free list.
package rsfl_pkg;

  localparam int unsigned SLOT_W = 8;
  localparam int unsigned SLOT_N = 256;
  localparam int unsigned ID_W = 64;
  localparam int unsigned SEG_W = 6;
  localparam int unsigned MAIN_W = 9;
  localparam int unsigned DB_W = 32;
  localparam int unsigned KIND_W = 2;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned IN_DATA_W = 80;
  localparam int unsigned OUT_DATA_W = 112;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 9;

  // Configuration values after reset.
  localparam logic [SEG_W-1:0] CFG_MAX_SEG_RST = 6'd1;
  localparam logic [MAIN_W-1:0] CFG_MAIN_RST = 9'd128;
  localparam logic CFG_WAITQ_RST = 1'b1;

  typedef enum logic [KIND_W-1:0] {
    KIND_POST  = 2'd0,
    KIND_FREE  = 2'd1,
    KIND_FAULT = 2'd2,
    KIND_INIT  = 2'd3
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_TOO_MANY = 2'd1,
    STAT_FULL     = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_SEGMENTS = 2'd0,
    CFG_MAIN_SLOTS   = 2'd1,
    CFG_WAITQ_ENABLE = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_POST,
    ST_FAULT1,
    ST_FAULT2
  } state_t;

  typedef struct packed {
    logic [SEG_W-1:0]  max_segments;
    logic [MAIN_W-1:0] main_slots;
    logic              waitq_enable;
  } cfg_t;

  typedef struct packed {
    status_t           status;
    logic [SLOT_W-1:0] taken_slot;
    logic [ID_W-1:0]   stored_id;
    logic [DB_W-1:0]   doorbell_value;
    logic              doorbell_valid;
  } result_t;

endpackage

// ----- rtl/rsfl_link_ram.sv -----
// Link table memory: one write port and two registered read ports.
module rsfl_link_ram #(
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [$clog2(DEPTH)-1:0] wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [$clog2(DEPTH)-1:0] rdata_a,
  output logic [$clog2(DEPTH)-1:0] rdata_b
);

  localparam int unsigned AW = $clog2(DEPTH);

  logic [AW-1:0] mem [DEPTH];

  // A read at the address being written returns the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ----- rtl/rsfl_id_ram.sv -----
// Request id memory: one write port and one registered read port.
module rsfl_id_ram
  import rsfl_pkg::*;
#(
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [ID_W-1:0]          wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [ID_W-1:0]          rdata
);

  logic [ID_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/rsfl_ctrl.sv -----
// Sequencer that walks the link and id memories for each request.
module rsfl_ctrl
  import rsfl_pkg::*;
#(
  parameter int unsigned SLOTS = 256
) (
  input  logic                     clk,
  input  logic                     rst,
  input  cfg_t                     cfg,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  kind_t                    in_kind,
  input  logic [SLOT_W-1:0]        in_slot,
  input  logic [ID_W-1:0]          in_request_id,
  input  logic [SEG_W-1:0]         in_segment_count,
  input  logic                     can_take,
  output logic                     res_load,
  output result_t                  res,
  output logic                     link_we,
  output logic [$clog2(SLOTS)-1:0] link_waddr,
  output logic [$clog2(SLOTS)-1:0] link_wdata,
  output logic [$clog2(SLOTS)-1:0] link_raddr_a,
  output logic [$clog2(SLOTS)-1:0] link_raddr_b,
  input  logic [$clog2(SLOTS)-1:0] link_rdata_a,
  input  logic [$clog2(SLOTS)-1:0] link_rdata_b,
  output logic                     id_we,
  output logic [$clog2(SLOTS)-1:0] id_waddr,
  output logic [ID_W-1:0]          id_wdata,
  output logic [$clog2(SLOTS)-1:0] id_raddr,
  input  logic [ID_W-1:0]          id_rdata
);

  localparam int unsigned PW = $clog2(SLOTS);
  localparam int unsigned EW = (PW + 1 > MAIN_W) ? PW + 1 : MAIN_W;
  localparam logic [EW-1:0] SLOTS_E = EW'(SLOTS);
  localparam logic [PW-1:0] LAST_SLOT = PW'(SLOTS - 1);
  localparam int unsigned RST_MAIN = (int'(CFG_MAIN_RST) > SLOTS) ? SLOTS : int'(CFG_MAIN_RST);
  localparam logic RST_WQ = CFG_WAITQ_RST && (RST_MAIN < SLOTS);
  localparam logic [PW-1:0] RST_TAIL = PW'(RST_MAIN - 1);
  localparam logic [PW-1:0] RST_WHEAD = RST_WQ ? PW'(RST_MAIN) : '0;
  localparam logic [PW-1:0] RST_WTAIL = RST_WQ ? LAST_SLOT : '0;

  state_t state, state_next;
  logic [PW-1:0] head, head_next;
  logic [PW-1:0] tail, tail_next;
  logic [PW-1:0] whead, whead_next;
  logic [PW-1:0] wtail, wtail_next;
  logic waitq_on, waitq_on_next;
  logic [DB_W-1:0] post_counter, post_counter_next;
  logic [PW-1:0] sweep_idx, sweep_idx_next;
  logic sweep_all, sweep_all_next;
  logic fwd_a, fwd_a_next;
  logic fwd_b, fwd_b_next;

  logic in_accept;
  logic [PW-1:0] slot_m;
  logic [PW-1:0] slot_tab [SLOT_N];
  logic [EW-1:0] main_e;
  logic [EW-1:0] eff_main;
  logic rb_waitq;
  logic sweep_hit;

  // Slot numbers from the request are reduced modulo the slot count.
  for (genvar g = 0; g < SLOT_N; g++) begin : g_slot_tab
    localparam int unsigned SM = g % SLOTS;
    assign slot_tab[g] = SM[PW-1:0];
  end

  assign slot_m = slot_tab[in_slot];
  assign in_ready = (state == ST_IDLE) && can_take;
  assign in_accept = in_valid && in_ready;

  // Pointer layout rebuilt from the configuration on an init request.
  assign main_e = EW'(cfg.main_slots);
  assign eff_main = (main_e < EW'(2)) ? EW'(2) : ((main_e > SLOTS_E) ? SLOTS_E : main_e);
  assign rb_waitq = cfg.waitq_enable && (eff_main < SLOTS_E);

  assign sweep_hit = sweep_all || (sweep_idx < tail) ||
                     (waitq_on && (sweep_idx >= whead) && (sweep_idx < wtail));

  // Reads run every cycle; the link ports always look at the two list heads.
  assign link_raddr_a = whead;
  assign link_raddr_b = head;
  assign id_raddr = slot_m;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_SWEEP;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    head_next = head;
    tail_next = tail;
    whead_next = whead;
    wtail_next = wtail;
    waitq_on_next = waitq_on;
    post_counter_next = post_counter;
    sweep_idx_next = sweep_idx;
    sweep_all_next = sweep_all;
    fwd_a_next = fwd_a;
    fwd_b_next = fwd_b;
    link_we = 1'b0;
    link_waddr = tail;
    link_wdata = slot_m;
    id_we = 1'b0;
    id_waddr = head;
    id_wdata = in_request_id;
    res_load = 1'b0;
    res.status = STAT_OK;
    res.taken_slot = '0;
    res.stored_id = '0;
    res.doorbell_value = post_counter;
    res.doorbell_valid = 1'b0;

    case (state)
      ST_SWEEP: begin
        link_we = sweep_hit;
        link_waddr = sweep_idx;
        link_wdata = (sweep_idx == LAST_SLOT) ? '0 : sweep_idx + PW'(1);
        if (sweep_idx == LAST_SLOT) begin
          res_load = !sweep_all;
          state_next = ST_IDLE;
        end else begin
          sweep_idx_next = sweep_idx + PW'(1);
        end
      end

      ST_IDLE: begin
        if (in_accept) begin
          case (in_kind)
            KIND_POST: begin
              res_load = 1'b1;
              if (in_segment_count > cfg.max_segments) begin
                res.status = STAT_TOO_MANY;
              end else if (head == tail) begin
                res.status = STAT_FULL;
              end else begin
                id_we = 1'b1;
                res.taken_slot = SLOT_W'(head);
                res.stored_id = in_request_id;
                res.doorbell_value = post_counter + DB_W'(1);
                res.doorbell_valid = 1'b1;
                post_counter_next = post_counter + DB_W'(1);
                state_next = ST_POST;
              end
            end
            KIND_FREE: begin
              link_we = 1'b1;
              tail_next = slot_m;
              res_load = 1'b1;
            end
            KIND_FAULT: begin
              link_we = 1'b1;
              if (waitq_on) begin
                link_waddr = wtail;
                wtail_next = slot_m;
              end else begin
                tail_next = slot_m;
              end
              state_next = ST_FAULT1;
            end
            KIND_INIT: begin
              head_next = '0;
              tail_next = PW'(eff_main - EW'(1));
              waitq_on_next = rb_waitq;
              whead_next = rb_waitq ? PW'(eff_main) : '0;
              wtail_next = rb_waitq ? LAST_SLOT : '0;
              sweep_idx_next = '0;
              sweep_all_next = 1'b0;
              state_next = ST_SWEEP;
            end
            default: begin
              state_next = ST_IDLE;
            end
          endcase
        end
      end

      ST_POST: begin
        head_next = link_rdata_b;
        state_next = ST_IDLE;
      end

      ST_FAULT1: begin
        // With the wait queue on, its first slot joins the main tail; the head reads issued
        // here would miss this write, so a same-address hit is forwarded.
        if (waitq_on) begin
          link_we = 1'b1;
          link_wdata = whead;
          tail_next = whead;
        end
        fwd_a_next = waitq_on && (whead == tail);
        fwd_b_next = waitq_on && (head == tail);
        id_we = 1'b1;
        id_wdata = id_rdata;
        res_load = 1'b1;
        res.taken_slot = SLOT_W'(head);
        res.stored_id = id_rdata;
        res.doorbell_value = post_counter + DB_W'(1);
        res.doorbell_valid = 1'b1;
        post_counter_next = post_counter + DB_W'(1);
        state_next = ST_FAULT2;
      end

      ST_FAULT2: begin
        if (waitq_on) begin
          whead_next = fwd_a ? tail : link_rdata_a;
        end
        head_next = fwd_b ? tail : link_rdata_b;
        state_next = ST_IDLE;
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= RST_TAIL;
      whead <= RST_WHEAD;
      wtail <= RST_WTAIL;
      waitq_on <= RST_WQ;
      post_counter <= '0;
      sweep_idx <= '0;
      sweep_all <= 1'b1;
      fwd_a <= 1'b0;
      fwd_b <= 1'b0;
    end else begin
      head <= head_next;
      tail <= tail_next;
      whead <= whead_next;
      wtail <= wtail_next;
      waitq_on <= waitq_on_next;
      post_counter <= post_counter_next;
      sweep_idx <= sweep_idx_next;
      sweep_all <= sweep_all_next;
      fwd_a <= fwd_a_next;
      fwd_b <= fwd_b_next;
    end
  end

  a_link_addr_range: assert property (@(posedge clk) disable iff (rst)
    link_we |-> ({1'b0, link_waddr} < (PW + 1)'(SLOTS)))
    else $error("link table write beyond the slot count");

  a_doorbell_count: assert property (@(posedge clk) disable iff (rst)
    res_load |-> (res.doorbell_value ==
                  (res.doorbell_valid ? post_counter + DB_W'(1) : post_counter)))
    else $error("doorbell value does not track the post counter");

  a_fault_head_hold: assert property (@(posedge clk) disable iff (rst)
    state == ST_FAULT1 |=> (state == ST_FAULT2) && (head == $past(head)))
    else $error("fault repost left its sequence or moved the head early");

endmodule

// ----- rtl/rsfl_out_buf.sv -----
// Result buffer: one pending entry in front of the output register.
module rsfl_out_buf
  import rsfl_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    res_load,
  input  result_t res_in,
  output logic    can_take,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_res
);

  logic    pend;
  result_t pend_res;
  logic    move;

  assign move = pend && (!out_valid || out_ready);
  assign can_take = !pend || move;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (res_load) begin
        pend <= 1'b1;
      end else if (move) begin
        pend <= 1'b0;
      end
      if (move) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      pend_res <= res_in;
    end
    if (move) begin
      out_res <= pend_res;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    res_load |-> (!pend || move))
    else $error("result loaded over a pending result");

endmodule

// ----- rtl/receive_slot_free_list.sv -----
// Top level of the receive slot free list with its configuration registers.
// An accepted post passes the idle and post states, a refused post or a free
// only the idle state, a fault completion the idle state and both fault states;
// each step works on the single link table memory and its registered reads.
// An init request walks every link table entry.
// A result passes the pending register and then the output register to m_axis.
// After reset the link table is rebuilt by a sweep; requests wait.
// Reset is synchronous and returns pointers, the post counter and registers to
// their reset values.
module receive_slot_free_list
  import rsfl_pkg::*;
#(
  parameter int unsigned SLOTS = 256
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // slot [7:0], request_id [71:8], segment_count [77:72], zeros above
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // kind [1:0]
  input  logic [KIND_W-1:0]     s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // taken_slot [7:0], stored_id [71:8], doorbell_value [103:72],
  // doorbell_valid [104], zeros above
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // status [1:0]
  output logic [STATUS_W-1:0]   m_axis_tuser,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int unsigned PW = $clog2(SLOTS);

  cfg_t    cfg;
  logic    can_take;
  logic    res_load;
  result_t res;
  result_t out_res;

  logic          link_we;
  logic [PW-1:0] link_waddr;
  logic [PW-1:0] link_wdata;
  logic [PW-1:0] link_raddr_a;
  logic [PW-1:0] link_raddr_b;
  logic [PW-1:0] link_rdata_a;
  logic [PW-1:0] link_rdata_b;
  logic            id_we;
  logic [PW-1:0]   id_waddr;
  logic [ID_W-1:0] id_wdata;
  logic [PW-1:0]   id_raddr;
  logic [ID_W-1:0] id_rdata;

  // Register writes are always taken; an index outside the list is ignored.
  // Main size and wait queue shape the lists only at reset and init.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_segments <= CFG_MAX_SEG_RST;
      cfg.main_slots <= CFG_MAIN_RST;
      cfg.waitq_enable <= CFG_WAITQ_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MAX_SEGMENTS: cfg.max_segments <= cfg_data[SEG_W-1:0];
        CFG_MAIN_SLOTS:   cfg.main_slots <= cfg_data[MAIN_W-1:0];
        CFG_WAITQ_ENABLE: cfg.waitq_enable <= cfg_data[0];
        default: begin
          cfg.max_segments <= cfg.max_segments;
        end
      endcase
    end
  end

  // The sequencer owns all pointers; the free list itself lives in the link
  // table, where entry n names the slot that follows slot n.
  rsfl_ctrl #(
    .SLOTS(SLOTS)
  ) u_ctrl (
    .clk              (clk),
    .rst              (rst),
    .cfg              (cfg),
    .in_valid         (s_axis_tvalid),
    .in_ready         (s_axis_tready),
    .in_kind          (kind_t'(s_axis_tuser)),
    .in_slot          (s_axis_tdata[7:0]),
    .in_request_id    (s_axis_tdata[71:8]),
    .in_segment_count (s_axis_tdata[77:72]),
    .can_take         (can_take),
    .res_load         (res_load),
    .res              (res),
    .link_we          (link_we),
    .link_waddr       (link_waddr),
    .link_wdata       (link_wdata),
    .link_raddr_a     (link_raddr_a),
    .link_raddr_b     (link_raddr_b),
    .link_rdata_a     (link_rdata_a),
    .link_rdata_b     (link_rdata_b),
    .id_we            (id_we),
    .id_waddr         (id_waddr),
    .id_wdata         (id_wdata),
    .id_raddr         (id_raddr),
    .id_rdata         (id_rdata)
  );

  rsfl_link_ram #(
    .DEPTH(SLOTS)
  ) u_link_ram (
    .clk     (clk),
    .we      (link_we),
    .waddr   (link_waddr),
    .wdata   (link_wdata),
    .raddr_a (link_raddr_a),
    .raddr_b (link_raddr_b),
    .rdata_a (link_rdata_a),
    .rdata_b (link_rdata_b)
  );

  // Request ids are stored per slot; entries hold nothing meaningful until
  // a post or a repost has written them.
  rsfl_id_ram #(
    .DEPTH(SLOTS)
  ) u_id_ram (
    .clk   (clk),
    .we    (id_we),
    .waddr (id_waddr),
    .wdata (id_wdata),
    .raddr (id_raddr),
    .rdata (id_rdata)
  );

  // The buffer lets the next request in while a result waits for m_axis.
  rsfl_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .res_load  (res_load),
    .res_in    (res),
    .can_take  (can_take),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (out_res)
  );

  assign m_axis_tdata = {7'd0, out_res.doorbell_valid, out_res.doorbell_value,
                         out_res.stored_id, out_res.taken_slot};
  assign m_axis_tuser = out_res.status;

endmodule

// ----- test/tb_receive_slot_free_list.sv -----
// Self-checking testbench for the receive slot free list: directed table, then random requests.
`timescale 1ns / 1ps

module tb_receive_slot_free_list;
  import rsfl_pkg::*;

  // One row of the directed table. A row with reconf set first rewrites all three
  // registers (the row itself is then an init request). A pinned row carries its
  // expected result typed in; every other row is checked against the predictor.
  typedef struct packed {
    bit                reconf;
    logic [SEG_W-1:0]  max_seg;
    logic [MAIN_W-1:0] main_n;
    logic              wq_en;
    kind_t             kind;
    logic [SLOT_W-1:0] slot;
    logic [ID_W-1:0]   rid;
    logic [SEG_W-1:0]  seg;
    bit                pinned;
    result_t           want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  // slot [7:0], request_id [71:8], segment_count [77:72], zeros above
  logic [IN_DATA_W-1:0] s_axis_tdata = '0;
  // kind [1:0]
  logic [KIND_W-1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  // taken_slot [7:0], stored_id [71:8], doorbell_value [103:72], doorbell_valid [104]
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  // status [1:0]
  logic [STATUS_W-1:0] m_axis_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  receive_slot_free_list #(.SLOTS(SLOT_N)) DUT (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // 20 ns clock period.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: our own copy of the link table, the id table, the list
  // pointers, the doorbell counter and the registers.
  // ---------------------------------------------------------------------------
  logic [SLOT_W-1:0] link_next [SLOT_N];
  logic [ID_W-1:0]   slot_rid  [SLOT_N];
  bit                rid_known [SLOT_N];   // id entry written at least once
  logic [SLOT_W-1:0] fl_head, fl_tail, wq_head, wq_tail;
  logic [DB_W-1:0]   post_count;
  bit                wq_on;
  logic [SEG_W-1:0]  reg_max_seg;
  logic [MAIN_W-1:0] reg_main;
  logic              reg_wq;

  // Results that the block owes us, oldest first.
  result_t pending_results [$];
  // Slots currently handed out by a post or repost; frees and fault completions
  // of well-formed traffic return these.
  logic [SLOT_W-1:0] out_slots [$];

  int errors = 0;
  int n_post = 0, n_free = 0, n_fault = 0, n_init = 0;
  int n_full = 0, n_too_many = 0, n_results = 0, n_settings = 1;
  bit steady = 1'b0;     // no idling on either side while set
  bit hold_req = 1'b0;   // asks the receiver for its long hold-off
  int hold_count = 0;

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= 40) $display("MISMATCH @%0t: %s", $realtime, msg);
  endtask

  // Rebuilds pointers and links from the registers, as an init request does.
  // The main size is clamped to [2, SLOT_N]; the wait queue only exists when it
  // is enabled and there is room above the main region.
  function automatic void relink();
    int m;
    m = int'(reg_main);
    if (m < 2) m = 2;
    if (m > SLOT_N) m = SLOT_N;
    fl_head = '0;
    fl_tail = SLOT_W'(m - 1);
    wq_on = reg_wq && (m < SLOT_N);
    if (wq_on) begin
      wq_head = SLOT_W'(m);
      wq_tail = SLOT_W'(SLOT_N - 1);
    end else begin
      wq_head = '0;
      wq_tail = '0;
    end
    for (int i = 0; i < int'(fl_tail); i++) link_next[i] = SLOT_W'(i + 1);
    if (wq_on)
      for (int i = int'(wq_head); i < int'(wq_tail); i++) link_next[i] = SLOT_W'(i + 1);
  endfunction

  function automatic void reset_free_list();
    for (int i = 0; i < SLOT_N; i++) begin
      link_next[i] = SLOT_W'(i + 1);
      slot_rid[i] = '0;
      rid_known[i] = 1'b0;
    end
    post_count = '0;
    reg_max_seg = CFG_MAX_SEG_RST;
    reg_main = CFG_MAIN_RST;
    reg_wq = CFG_WAITQ_RST;
    relink();
  endfunction

  // Applies one request to the predictor state and returns the result it owes.
  function automatic result_t advance_free_list(input kind_t k, input logic [SLOT_W-1:0] s,
                                                input logic [ID_W-1:0] rid,
                                                input logic [SEG_W-1:0] seg);
    result_t r;
    r = '0;
    r.status = STAT_OK;
    case (k)
      KIND_POST: begin
        // The segment check wins when both checks fail.
        if (seg > reg_max_seg) begin
          r.status = STAT_TOO_MANY;
        end else if (fl_head == fl_tail) begin
          r.status = STAT_FULL;
        end else begin
          slot_rid[fl_head] = rid;
          rid_known[fl_head] = 1'b1;
          r.taken_slot = fl_head;
          r.stored_id = rid;
          fl_head = link_next[fl_head];
          post_count++;
          r.doorbell_valid = 1'b1;
        end
      end
      KIND_FREE: begin
        link_next[fl_tail] = s;
        fl_tail = s;
      end
      KIND_FAULT: begin
        // Park the slot in the wait queue and promote the wait queue's first
        // slot to the main tail, or append the slot itself without a wait queue.
        if (wq_on) begin
          link_next[wq_tail] = s;
          wq_tail = s;
          link_next[fl_tail] = wq_head;
          fl_tail = wq_head;
          wq_head = link_next[wq_head];
        end else begin
          link_next[fl_tail] = s;
          fl_tail = s;
        end
        // The repost skips the full check and always advances the head.
        slot_rid[fl_head] = slot_rid[s];
        rid_known[fl_head] = 1'b1;
        r.taken_slot = fl_head;
        r.stored_id = slot_rid[fl_head];
        fl_head = link_next[fl_head];
        post_count++;
        r.doorbell_valid = 1'b1;
      end
      default: relink();
    endcase
    r.doorbell_value = post_count;
    return r;
  endfunction

  // Offers one request on the slave side. Random idle cycles come first; valid
  // stays high across back-to-back requests. The expected result is queued at
  // the edge that accepts the request.
  task automatic send_request(input kind_t k, input logic [SLOT_W-1:0] s,
                              input logic [ID_W-1:0] rid, input logic [SEG_W-1:0] seg,
                              input bit pinned, input result_t want, output result_t r);
    r = advance_free_list(k, s, rid, seg);
    @(negedge clk);
    while (!steady && $urandom_range(0, 99) < 32) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {2'b00, seg, rid, s};
    s_axis_tuser <= k;
    do @(posedge clk); while (!s_axis_tready);
    pending_results.push_back(pinned ? want : r);
    case (k)
      KIND_POST: n_post++;
      KIND_FREE: n_free++;
      KIND_FAULT: n_fault++;
      default: n_init++;
    endcase
    if (r.status == STAT_FULL) n_full++;
    if (r.status == STAT_TOO_MANY) n_too_many++;
  endtask

  // Drops valid and waits until every owed result has come back.
  task automatic drain_results();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_MAX_SEGMENTS: reg_max_seg = val[SEG_W-1:0];
      CFG_MAIN_SLOTS: reg_main = val[MAIN_W-1:0];
      default: reg_wq = val[0];
    endcase
  endtask

  // Register writes happen only with the block idle: drain, let the output
  // pipeline settle, then write all three registers.
  task automatic set_regs(input logic [SEG_W-1:0] max_seg, input logic [MAIN_W-1:0] main_n,
                          input logic wq_en);
    drain_results();
    repeat (6) @(posedge clk);
    write_reg(CFG_MAX_SEGMENTS, CFG_DATA_W'(max_seg));
    write_reg(CFG_MAIN_SLOTS, main_n);
    write_reg(CFG_WAITQ_ENABLE, CFG_DATA_W'(wq_en));
    @(negedge clk);
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random back-pressure, none while steady is set, and one long
  // hold-off, counted here, once the stimulus asks for it.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_req && hold_count < 400) begin
      m_axis_tready <= 1'b0;
      hold_count <= hold_count + 1;
    end else if (steady) begin
      m_axis_tready <= 1'b1;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= 32);
    end
  end

  // Result checker: each accepted result against the oldest expectation.
  always @(posedge clk) begin
    result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      n_results++;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected: tdata %h tuser %0d",
                                  m_axis_tdata, m_axis_tuser));
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tuser !== want.status)
          report_mismatch($sformatf("status got %0d want %0d", m_axis_tuser, want.status));
        if (m_axis_tdata[7:0] !== want.taken_slot)
          report_mismatch($sformatf("taken_slot got %0d want %0d",
                                    m_axis_tdata[7:0], want.taken_slot));
        if (m_axis_tdata[71:8] !== want.stored_id)
          report_mismatch($sformatf("stored_id got %h want %h",
                                    m_axis_tdata[71:8], want.stored_id));
        if (m_axis_tdata[103:72] !== want.doorbell_value)
          report_mismatch($sformatf("doorbell_value got %0d want %0d",
                                    m_axis_tdata[103:72], want.doorbell_value));
        if (m_axis_tdata[104] !== want.doorbell_valid)
          report_mismatch($sformatf("doorbell_valid got %b want %b",
                                    m_axis_tdata[104], want.doorbell_valid));
      end
    end
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #(20 * 400000);
    $display("receive_slot_free_list test failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Directed table. After reset the registers hold max_segments 1, main_slots
  // 128 and the wait queue on, so the first rows can be read off directly: the
  // first posts take slots 0 and 1 and ring the doorbell with 1 and 2, oversize
  // posts are refused with the counter held, and a free returns zeros but the counter value.
  // Later rows cover a repost on a full list, a two-slot list with and without
  // a wait queue, a main size below 2 and above SLOT_N, and the segment check
  // winning over the full check.
  // ---------------------------------------------------------------------------
  dir_row_t dir_rows [24] = '{
    '{0, 6'd0, 9'd0, 1'b0, KIND_POST, 8'h00, 64'hFFFF_FFFF_FFFF_FFFF, 6'd1, 1,
      '{STAT_OK, 8'd0, 64'hFFFF_FFFF_FFFF_FFFF, 32'd1, 1'b1}},
    '{0, 6'd0, 9'd0, 1'b0, KIND_POST, 8'hFF, 64'd0, 6'd0, 1,
      '{STAT_OK, 8'd1, 64'd0, 32'd2, 1'b1}},
    '{0, 6'd0, 9'd0, 1'b0, KIND_POST, 8'h00, 64'd1, 6'd2, 1,
      '{STAT_TOO_MANY, 8'd0, 64'd0, 32'd2, 1'b0}},
    '{0, 6'd0, 9'd0, 1'b0, KIND_POST, 8'h00, 64'h8000_0000_0000_0000, 6'd63, 1,
      '{STAT_TOO_MANY, 8'd0, 64'd0, 32'd2, 1'b0}},
    '{0, 6'd0, 9'd0, 1'b0, KIND_FREE, 8'h00, 64'd0, 6'd0, 1,
      '{STAT_OK, 8'd0, 64'd0, 32'd2, 1'b0}},
    '{0, 6'd0, 9'd0, 1'b0, KIND_FAULT, 8'h01, 64'd0, 6'd0, 0, '0},
    '{0, 6'd0, 9'd0, 1'b0, KIND_FAULT, 8'h00, 64'd0, 6'd0, 0, '0},
    '{0, 6'd0, 9'd0, 1'b0, KIND_POST, 8'h00, 64'h0123_4567_89AB_CDEF, 6'd1, 0, '0},
    '{0, 6'd0, 9'd0, 1'b0, KIND_INIT, 8'hAA, 64'd0, 6'd0, 0, '0},
    // Two-slot list without a wait queue: one post fills it.
    '{1, 6'd63, 9'd2, 1'b0, KIND_INIT, 8'h00, 64'd0, 6'd0, 0, '0},
    '{0, 6'd0, 9'd0, 1'b0, KIND_POST, 8'h00, 64'h5A5A_5A5A_A5A5_A5A5, 6'd63, 0, '0},
    '{0, 6'd0, 9'd0, 1'b0, KIND_POST, 8'h00, 64'd7, 6'd0, 0, '0},
    '{0, 6'd0, 9'd0, 1'b0, KIND_FAULT, 8'h00, 64'd0, 6'd0, 0, '0},
    '{0, 6'd0, 9'd0, 1'b0, KIND_FREE, 8'hFF, 64'd0, 6'd0, 0, '0},
    // Main size 0 clamps to 2; the wait queue spans the rest of the table.
    '{1, 6'd0, 9'd0, 1'b1, KIND_INIT, 8'h00, 64'd0, 6'd0, 0, '0},
    '{0, 6'd0, 9'd0, 1'b0, KIND_POST, 8'h00, 64'hFEDC_BA98_7654_3210, 6'd0, 0, '0},
    '{0, 6'd0, 9'd0, 1'b0, KIND_POST, 8'h00, 64'd9, 6'd1, 0, '0},
    '{0, 6'd0, 9'd0, 1'b0, KIND_POST, 8'h00, 64'd9, 6'd0, 0, '0},
    '{0, 6'd0, 9'd0, 1'b0, KIND_FAULT, 8'h00, 64'd0, 6'd0, 0, '0},
    // Main size 511 clamps to SLOT_N, which leaves no room for a wait queue.
    '{1, 6'd31, 9'd511, 1'b1, KIND_INIT, 8'h00, 64'd0, 6'd0, 0, '0},
    '{0, 6'd0, 9'd0, 1'b0, KIND_POST, 8'h00, 64'h0F0F_F0F0_3C3C_C3C3, 6'd31, 0, '0},
    '{0, 6'd0, 9'd0, 1'b0, KIND_POST, 8'h00, 64'd3, 6'd32, 0, '0},
    '{0, 6'd0, 9'd0, 1'b0, KIND_FAULT, 8'h00, 64'd0, 6'd0, 0, '0},
    '{0, 6'd0, 9'd0, 1'b0, KIND_FREE, 8'h80, 64'd0, 6'd0, 0, '0}
  };

  // ---------------------------------------------------------------------------
  // Main stimulus.
  // ---------------------------------------------------------------------------
  initial begin
    result_t r;
    kind_t k;
    logic [SLOT_W-1:0] s;
    logic [ID_W-1:0] rid;
    logic [SEG_W-1:0] seg;
    int roll, pick, waited;

    reset_free_list();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].reconf)
        set_regs(dir_rows[i].max_seg, dir_rows[i].main_n, dir_rows[i].wq_en);
      send_request(dir_rows[i].kind, dir_rows[i].slot, dir_rows[i].rid, dir_rows[i].seg,
                   dir_rows[i].pinned, dir_rows[i].want, r);
    end

    // Random phases, each under its own register setting and started by an
    // init. Phase 2 runs with no idling at all; phase 3 carries the long
    // receiver hold-off while the sender keeps offering requests.
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: set_regs(6'd63, 9'd256, 1'b1);
        1: set_regs(6'd0, 9'd2, 1'b1);
        2: set_regs(SEG_W'($urandom_range(0, 63)), 9'd255, 1'b1);
        3: set_regs(SEG_W'($urandom_range(0, 63)), MAIN_W'($urandom_range(2, 256)),
                    1'($urandom_range(0, 1)));
        4: set_regs(6'd63, 9'd64, 1'b0);
        default: set_regs(SEG_W'($urandom_range(0, 63)), MAIN_W'($urandom_range(0, 511)),
                          1'($urandom_range(0, 1)));
      endcase
      steady = (p == 2);
      send_request(KIND_INIT, SLOT_W'($urandom), {$urandom, $urandom}, SEG_W'($urandom),
                   1'b0, '0, r);
      out_slots.delete();

      for (int n = 0; n < 288; n++) begin
        if (p == 3 && n == 40) hold_req = 1'b1;
        roll = $urandom_range(0, 99);
        s = SLOT_W'($urandom_range(0, 255));
        rid = {$urandom, $urandom};
        seg = SEG_W'($urandom_range(0, 63));
        if (roll < 1) begin
          k = KIND_INIT;
        end else if (roll < 42) begin
          // Mostly legal segment counts, sometimes anything.
          k = KIND_POST;
          if ($urandom_range(0, 9) != 0) seg = SEG_W'($urandom_range(0, int'(reg_max_seg)));
        end else if (roll < 72) begin
          // Free a slot we handed out; now and then an arbitrary slot.
          k = KIND_FREE;
          if (roll < 68 && out_slots.size() != 0) begin
            pick = $urandom_range(0, out_slots.size() - 1);
            s = out_slots[pick];
            out_slots.delete(pick);
          end
        end else if (roll < 97) begin
          // Fault completion of an outstanding slot, or of any slot whose
          // request id has been written. Slots never written are not used.
          k = KIND_FAULT;
          if (roll < 93 && out_slots.size() != 0) begin
            pick = $urandom_range(0, out_slots.size() - 1);
            s = out_slots[pick];
            out_slots.delete(pick);
          end else begin
            while (!rid_known[s]) s = SLOT_W'($urandom_range(0, 255));
          end
        end else begin
          k = KIND_POST;
        end
        send_request(k, s, rid, seg, 1'b0, '0, r);
        if (r.doorbell_valid) out_slots.push_back(r.taken_slot);
        if (k == KIND_INIT) out_slots.delete();
      end
    end
    steady = 1'b0;

    // Wait out the owed results, bounded, then a few quiet cycles so a stray
    // late result would still be caught.
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    waited = 0;
    while (pending_results.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d expected results never arrived",
                                pending_results.size()));

    $display("Sent %0d posts, %0d frees, %0d fault completions and %0d inits over %0d settings.",
             n_post, n_free, n_fault, n_init, n_settings);
    $display("Checked %0d results: %0d full refusals, %0d segment refusals, %0d mismatches.",
             n_results, n_full, n_too_many, errors);
    if (errors == 0) begin
      $display("receive_slot_free_list test passed");
    end else begin
      $display("receive_slot_free_list test failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/rsfl_pkg.sv
rtl/rsfl_link_ram.sv
rtl/rsfl_id_ram.sv
rtl/rsfl_ctrl.sv
rtl/rsfl_out_buf.sv
rtl/receive_slot_free_list.sv
test/tb_receive_slot_free_list.sv
